>>> rtl/core/bsc_pkg.sv
// Shared types, constants and helpers of the barometric compensation core.
`default_nettype none
package bsc_pkg;

  localparam int unsigned DIV_W = 32;

  // Stages from accept to done: 13 front stages, two dividers, 5 back stages.
  localparam int unsigned LATENCY = 2 * DIV_W + 18;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;
  localparam logic [2:0] REG_OSS     = 3'd5;

  localparam logic signed [31:0] B6_OFFSET   = 32'sd4000;
  localparam logic        [31:0] B4_BIAS     = 32'd32768;
  localparam logic        [31:0] B7_SCALE    = 32'd50000;
  localparam logic signed [31:0] P_SQ_COEF   = 32'sd3038;
  localparam logic signed [31:0] P_LIN_COEF  = -32'sd7357;
  localparam logic signed [31:0] P_OFFSET    = 32'sd3791;
  localparam logic signed [31:0] P_MAX       = 32'sd1048575;
  localparam logic signed [31:0] T_MAX       = 32'sd32767;
  localparam logic signed [31:0] T_MIN       = -32'sd32768;

  typedef struct packed {
    logic [31:0] ac1_ac2;
    logic [31:0] ac3_ac4;
    logic [31:0] ac5_ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
    logic [1:0]  oss;
  } cal_t;

  // Context that rides along the temperature divider.
  typedef struct packed {
    logic [31:0] x1t;
    logic        neg;
    logic        dz;
    logic [18:0] up;
  } temp_tag_t;

  // Context that rides along the pressure divider.
  typedef struct packed {
    logic [15:0] t;
    logic        err;
    logic        msb;
  } press_tag_t;

  // Low 32 bits of a product; same bits for signed and unsigned operands.
  function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    r = a * b;
    return r;
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/bsc_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage, with a side tag.
`default_nettype none
module bsc_div #(
  parameter int unsigned W  = 32,
  parameter int unsigned TW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_vld,
  input  wire logic [W-1:0]  dividend,
  input  wire logic [W-1:0]  divisor,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_vld,
  output logic [W-1:0]       quotient,
  output logic [TW-1:0]      out_tag
);

  logic [2*W-1:0] acc [W+1];
  logic [W-1:0]   dvs [W+1];
  logic [TW-1:0]  tag [W+1];
  logic           vld [W+1];

  assign acc[0] = {{W{1'b0}}, dividend};
  assign dvs[0] = divisor;
  assign tag[0] = in_tag;
  assign vld[0] = in_vld;

  for (genvar k = 0; k < W; k++) begin : gen_stage
    logic [W:0] top;
    logic [W:0] diff;
    logic       ge;

    assign top  = acc[k][2*W-1:W-1];
    assign diff = top - {1'b0, dvs[k]};
    assign ge   = !diff[W];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      acc[k+1] <= {(ge ? diff[W-1:0] : top[W-1:0]), acc[k][W-2:0], ge};
      dvs[k+1] <= dvs[k];
      tag[k+1] <= tag[k];
    end
  end

  assign out_vld  = vld[W];
  assign quotient = acc[W][W-1:0];
  assign out_tag  = tag[W];

endmodule
`default_nettype wire

>>> rtl/core/bsc_temp.sv
// Temperature front end: x1 term and the unsigned magnitude operands of the temperature divide, sign in the tag.
`default_nettype none
module bsc_temp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_vld,
  input  wire logic [15:0]       ut,
  input  wire logic [18:0]       up,
  input  wire bsc_pkg::cal_t     cal,
  output logic                   out_vld,
  output logic [31:0]            num,
  output logic [31:0]            den,
  output bsc_pkg::temp_tag_t     tag
);

  logic              v1, v2, v3;
  logic [16:0]       d1;
  logic [18:0]       up1, up2;
  logic [31:0]       p2;
  logic signed [31:0] x1t_c, den_c;
  logic [15:0]       mc, md, abs_mc;
  bsc_pkg::temp_tag_t tag3;
  logic [31:0]       den3;

  assign mc     = cal.mc_md[31:16];
  assign md     = cal.mc_md[15:0];
  assign abs_mc = mc[15] ? 16'(-mc) : mc;

  always_comb begin
    x1t_c = $signed(p2) >>> 15;
    den_c = x1t_c + $signed(bsc_pkg::sext16(md));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
    end
    d1  <= {1'b0, ut} - {1'b0, cal.ac5_ac6[15:0]};
    up1 <= up;
    p2  <= bsc_pkg::mul_lo({{15{d1[16]}}, d1}, {16'b0, cal.ac5_ac6[31:16]});
    up2 <= up1;
    tag3.x1t <= x1t_c;
    tag3.neg <= mc[15] ^ den_c[31];
    tag3.dz  <= (den_c == 32'sd0);
    tag3.up  <= up2;
    den3     <= den_c[31] ? 32'(-den_c) : den_c;
  end

  assign out_vld = v3;
  assign num     = {5'b0, abs_mc, 11'b0};
  assign den     = den3;
  assign tag     = tag3;

endmodule
`default_nettype wire

>>> rtl/core/bsc_press.sv
// Pressure coefficients: b3..b7, feeding the pressure divide, plus the saturated temperature.
`default_nettype none
module bsc_press (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_vld,
  input  wire logic [31:0]        quo,
  input  wire bsc_pkg::temp_tag_t in_tag,
  input  wire bsc_pkg::cal_t      cal,
  output logic                    out_vld,
  output logic [31:0]             dividend,
  output logic [31:0]             divisor,
  output bsc_pkg::press_tag_t     out_tag
);

  logic [13:4] v;
  logic signed [31:0] b5_4, b6_5, sqp6, a2p6, a3p6, sq7, a2_7, a3_7;
  logic signed [31:0] b2sq8, b1sq8, a2_8, a3_8, x3a9, x3b9, b3pre10, x3_10, b3_11;
  logic [31:0] b4p11, b4_12, diff12, b7_13, b4_13;
  logic [15:0] t5, t6, t7, t8, t9, t10, t11, t12, t13;
  logic dz4, dz5, dz6, dz7, dz8, dz9, dz10, dz11, err12, err13;
  logic [18:0] up4, up5, up6, up7, up8, up9, up10, up11;
  logic signed [31:0] q_c, tt_c, b3pre_c;
  logic [15:0] t_sat_c;
  logic signed [31:0] ac1s, ac2s, ac3s, b1s, b2s;

  assign ac1s = $signed(bsc_pkg::sext16(cal.ac1_ac2[31:16]));
  assign ac2s = $signed(bsc_pkg::sext16(cal.ac1_ac2[15:0]));
  assign ac3s = $signed(bsc_pkg::sext16(cal.ac3_ac4[31:16]));
  assign b1s  = $signed(bsc_pkg::sext16(cal.b1_b2[31:16]));
  assign b2s  = $signed(bsc_pkg::sext16(cal.b1_b2[15:0]));

  always_comb begin
    q_c  = in_tag.neg ? $signed(32'(-quo)) : $signed(quo);
    tt_c = (b5_4 + 32'sd8) >>> 4;
    priority if (tt_c > bsc_pkg::T_MAX) begin
      t_sat_c = 16'h7FFF;
    end else if (tt_c < bsc_pkg::T_MIN) begin
      t_sat_c = 16'h8000;
    end else begin
      t_sat_c = tt_c[15:0];
    end
    b3pre_c = (((ac1s <<< 2) + x3a9) <<< cal.oss) + 32'sd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[12:4], in_vld};
    end
    // b5
    b5_4 <= in_tag.x1t + q_c;
    dz4  <= in_tag.dz;
    up4  <= in_tag.up;
    // t and b6
    t5   <= t_sat_c;
    b6_5 <= b5_4 - bsc_pkg::B6_OFFSET;
    dz5  <= dz4;
    up5  <= up4;
    // products with b6
    sqp6 <= bsc_pkg::mul_lo(b6_5, b6_5);
    a2p6 <= bsc_pkg::mul_lo(ac2s, b6_5);
    a3p6 <= bsc_pkg::mul_lo(ac3s, b6_5);
    t6 <= t5; dz6 <= dz5; up6 <= up5;
    sq7  <= sqp6 >>> 12;
    a2_7 <= a2p6 >>> 11;
    a3_7 <= a3p6 >>> 13;
    t7 <= t6; dz7 <= dz6; up7 <= up6;
    b2sq8 <= bsc_pkg::mul_lo(b2s, sq7);
    b1sq8 <= bsc_pkg::mul_lo(b1s, sq7);
    a2_8  <= a2_7;
    a3_8  <= a3_7;
    t8 <= t7; dz8 <= dz7; up8 <= up7;
    x3a9 <= (b2sq8 >>> 11) + a2_8;
    x3b9 <= a3_8 + (b1sq8 >>> 16) + 32'sd2;
    t9 <= t8; dz9 <= dz8; up9 <= up8;
    b3pre10 <= b3pre_c;
    x3_10   <= x3b9 >>> 2;
    t10 <= t9; dz10 <= dz9; up10 <= up9;
    // truncate toward zero on the divide by four
    b3_11 <= b3pre10[31] ? ((b3pre10 + 32'sd3) >>> 2) : (b3pre10 >>> 2);
    b4p11 <= bsc_pkg::mul_lo({16'b0, cal.ac3_ac4[15:0]}, x3_10 + bsc_pkg::B4_BIAS);
    t11 <= t10; dz11 <= dz10; up11 <= up10;
    b4_12  <= b4p11 >> 15;
    err12  <= dz11 | ((b4p11 >> 15) == 32'd0);
    diff12 <= {13'b0, up11} - b3_11;
    t12 <= t11;
    b7_13 <= bsc_pkg::mul_lo(diff12, bsc_pkg::B7_SCALE >> cal.oss);
    b4_13 <= b4_12;
    err13 <= err12;
    t13   <= t12;
  end

  assign out_vld     = v[13];
  assign dividend    = b7_13[31] ? b7_13 : {b7_13[30:0], 1'b0};
  assign divisor     = b4_13;
  assign out_tag.t   = t13;
  assign out_tag.err = err13;
  assign out_tag.msb = b7_13[31];

endmodule
`default_nettype wire

>>> rtl/core/bsc_post.sv
// Pressure back end: second-order correction, saturation and result register.
`default_nettype none
module bsc_post (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_vld,
  input  wire logic [31:0]         quo,
  input  wire bsc_pkg::press_tag_t in_tag,
  output logic                     done,
  output logic signed [15:0]       temperature_tenths,
  output logic [19:0]              pressure_pa,
  output logic                     div_error
);

  logic [4:1] v;
  logic signed [31:0] p1, ps1, sq2, m2, p2, x1_3, x2_3, p3, s4, p4, pf_c;
  logic [15:0] t1, t2, t3, t4;
  logic e1, e2, e3, e4;
  logic [19:0] p_sat_c;

  always_comb begin
    pf_c = p4 + (s4 >>> 4);
    priority if (pf_c[31]) begin
      p_sat_c = 20'd0;
    end else if (pf_c > bsc_pkg::P_MAX) begin
      p_sat_c = 20'hFFFFF;
    end else begin
      p_sat_c = pf_c[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[3:1], in_vld};
      done <= v[4];
    end
    p1  <= in_tag.msb ? {quo[30:0], 1'b0} : quo;
    ps1 <= $signed(in_tag.msb ? {quo[30:0], 1'b0} : quo) >>> 8;
    t1 <= in_tag.t; e1 <= in_tag.err;
    sq2 <= bsc_pkg::mul_lo(ps1, ps1);
    m2  <= bsc_pkg::mul_lo(bsc_pkg::P_LIN_COEF, p1);
    p2  <= p1; t2 <= t1; e2 <= e1;
    x1_3 <= bsc_pkg::mul_lo(sq2, bsc_pkg::P_SQ_COEF);
    x2_3 <= m2 >>> 16;
    p3   <= p2; t3 <= t2; e3 <= e2;
    s4 <= (x1_3 >>> 16) + x2_3 + bsc_pkg::P_OFFSET;
    p4 <= p3; t4 <= t3; e4 <= e3;
    // zero both fields when a divisor was zero
    temperature_tenths <= e4 ? 16'sd0 : $signed(t4);
    pressure_pa        <= e4 ? 20'd0 : p_sat_c;
    div_error          <= e4;
  end

endmodule
`default_nettype wire

>>> rtl/core/baro_sensor_compensation_core.sv
// Top level: configuration registers and the compensation pipeline.
//
// Takes one raw temperature/pressure pair per clock and returns true temperature
// (0.1 degC) and pressure (Pa) with a one-cycle done strobe; busy is never
// asserted, so a new request may enter every cycle. The latency is set by the two
// 32-stage bit-per-stage dividers plus 18 multiply/add stages. The receiver cannot
// stall results. The user must write calibration and oversampling over the APB
// port only while no request is in flight; the block itself does not enforce it.
`default_nettype none
module baro_sensor_compensation_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [15:0]  raw_temperature,
  input  wire logic [18:0]  raw_pressure,
  output logic              done,
  output logic signed [15:0] temperature_tenths,
  output logic [19:0]       pressure_pa,
  output logic              div_error,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  bsc_pkg::cal_t      cal;
  logic               t_vld, td_vld, p_vld, pd_vld;
  logic [31:0]        t_num, t_den, t_quo, p_dvd, p_dvs, p_quo;
  bsc_pkg::temp_tag_t  t_tag, td_tag;
  bsc_pkg::press_tag_t p_tag, pd_tag;
  logic               wr_en;
  logic [2:0]         idx;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (wr_en) begin
      unique case (idx)
        bsc_pkg::REG_AC1_AC2: cal.ac1_ac2 <= pwdata;
        bsc_pkg::REG_AC3_AC4: cal.ac3_ac4 <= pwdata;
        bsc_pkg::REG_AC5_AC6: cal.ac5_ac6 <= pwdata;
        bsc_pkg::REG_B1_B2:   cal.b1_b2   <= pwdata;
        bsc_pkg::REG_MC_MD:   cal.mc_md   <= pwdata;
        bsc_pkg::REG_OSS:     cal.oss     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bsc_pkg::REG_AC1_AC2: prdata = cal.ac1_ac2;
      bsc_pkg::REG_AC3_AC4: prdata = cal.ac3_ac4;
      bsc_pkg::REG_AC5_AC6: prdata = cal.ac5_ac6;
      bsc_pkg::REG_B1_B2:   prdata = cal.b1_b2;
      bsc_pkg::REG_MC_MD:   prdata = cal.mc_md;
      bsc_pkg::REG_OSS:     prdata = {30'b0, cal.oss};
      default:              prdata = 32'b0;
    endcase
  end

  bsc_temp u_temp (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start & !busy),
    .ut      (raw_temperature),
    .up      (raw_pressure),
    .cal     (cal),
    .out_vld (t_vld),
    .num     (t_num),
    .den     (t_den),
    .tag     (t_tag)
  );

  bsc_div #(.W(bsc_pkg::DIV_W), .TW($bits(bsc_pkg::temp_tag_t))) u_tdiv (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (t_vld),
    .dividend (t_num),
    .divisor  (t_den),
    .in_tag   (t_tag),
    .out_vld  (td_vld),
    .quotient (t_quo),
    .out_tag  (td_tag)
  );

  bsc_press u_press (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (td_vld),
    .quo      (t_quo),
    .in_tag   (td_tag),
    .cal      (cal),
    .out_vld  (p_vld),
    .dividend (p_dvd),
    .divisor  (p_dvs),
    .out_tag  (p_tag)
  );

  bsc_div #(.W(bsc_pkg::DIV_W), .TW($bits(bsc_pkg::press_tag_t))) u_pdiv (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (p_vld),
    .dividend (p_dvd),
    .divisor  (p_dvs),
    .in_tag   (p_tag),
    .out_vld  (pd_vld),
    .quotient (p_quo),
    .out_tag  (pd_tag)
  );

  bsc_post u_post (
    .clk                (clk),
    .rst                (rst),
    .in_vld             (pd_vld),
    .quo                (p_quo),
    .in_tag             (pd_tag),
    .done               (done),
    .temperature_tenths (temperature_tenths),
    .pressure_pa        (pressure_pa),
    .div_error          (div_error)
  );

  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start & !busy, bsc_pkg::LATENCY))
    else $error("done without a matching request");

  a_request_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start & !busy) |-> ##(bsc_pkg::LATENCY) done)
    else $error("request lost in pipeline");

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    (done && div_error) |-> (temperature_tenths == 16'sd0 && pressure_pa == 20'd0))
    else $error("divide error with nonzero result");

endmodule
`default_nettype wire
